FILE: hdl/pfl_pkg.sv
package pfl_pkg;

  // PIN length in digits and the widths that follow from it.
  localparam int PIN_DIGITS = 4;
  localparam int DIGIT_W    = 4;
  localparam int ENTRY_W    = DIGIT_W * PIN_DIGITS;
  localparam int DCNT_W     = $clog2(PIN_DIGITS + 1);
  localparam int PIN_W      = 16;
  localparam int CMP_W      = (ENTRY_W > PIN_W) ? ENTRY_W : PIN_W;

  typedef enum logic [2:0] {
    PH_PIN     = 3'd0,
    PH_FINGER  = 3'd1,
    PH_REMOVE  = 3'd2,
    PH_OPEN    = 3'd3,
    PH_LOCKOUT = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PIN_OK    = 3'd1,
    EV_PIN_WRONG = 3'd2,
    EV_FP_DENIED = 3'd3,
    EV_FP_ERROR  = 3'd4,
    EV_UNLOCKED  = 3'd5,
    EV_FP_FAIL   = 3'd6,
    EV_CLEARED   = 3'd7
  } event_t;

  localparam logic [1:0] REQ_KEY  = 2'd0;
  localparam logic [1:0] REQ_FP   = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [1:0] FP_NONE    = 2'd0;
  localparam logic [1:0] FP_MATCH   = 2'd1;
  localparam logic [1:0] FP_NOMATCH = 2'd2;
  localparam logic [1:0] FP_ERROR   = 2'd3;

  localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [3:0] KEY_STAR       = 4'd10;

  localparam logic [2:0] CFG_PIN_CODE        = 3'd0;
  localparam logic [2:0] CFG_EXPECTED_FINGER = 3'd1;
  localparam logic [2:0] CFG_MAX_TRIES       = 3'd2;
  localparam logic [2:0] CFG_FINGER_TIMEOUT  = 3'd3;
  localparam logic [2:0] CFG_LOCKOUT_TICKS   = 3'd4;
  localparam logic [2:0] CFG_UNLOCK_TICKS    = 3'd5;

  localparam logic [15:0] RST_PIN_CODE        = 16'h2005;
  localparam logic [9:0]  RST_EXPECTED_FINGER = 10'd1;
  localparam logic [3:0]  RST_MAX_TRIES       = 4'd3;
  localparam logic [15:0] RST_FINGER_TIMEOUT  = 16'd15000;
  localparam logic [15:0] RST_LOCKOUT_TICKS   = 16'd10000;
  localparam logic [15:0] RST_UNLOCK_TICKS    = 16'd5000;

  localparam logic [3:0]  TRY_MAX     = 4'hF;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] pin_code;
    logic [9:0]  expected_finger;
    logic [3:0]  max_tries;
    logic [15:0] finger_timeout;
    logic [15:0] lockout_ticks;
    logic [15:0] unlock_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] key_code;
    logic [1:0] fp_status;
    logic [9:0] fp_id;
  } item_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] digits_entered;
    event_t     event_code;
    logic [3:0] tries_used;
    logic       unlock;
  } result_t;

endpackage

FILE: hdl/pfl_cfg.sv
module pfl_cfg (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  output pfl_pkg::cfg_t   cfg
);
  import pfl_pkg::*;

  // Writes to indexes past the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pin_code        <= RST_PIN_CODE;
      cfg.expected_finger <= RST_EXPECTED_FINGER;
      cfg.max_tries       <= RST_MAX_TRIES;
      cfg.finger_timeout  <= RST_FINGER_TIMEOUT;
      cfg.lockout_ticks   <= RST_LOCKOUT_TICKS;
      cfg.unlock_ticks    <= RST_UNLOCK_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIN_CODE:        cfg.pin_code        <= cfg_data;
        CFG_EXPECTED_FINGER: cfg.expected_finger <= cfg_data[9:0];
        CFG_MAX_TRIES:       cfg.max_tries       <= cfg_data[3:0];
        CFG_FINGER_TIMEOUT:  cfg.finger_timeout  <= cfg_data;
        CFG_LOCKOUT_TICKS:   cfg.lockout_ticks   <= cfg_data;
        CFG_UNLOCK_TICKS:    cfg.unlock_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/pfl_core.sv
module pfl_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  pfl_pkg::item_t    item,
  input  pfl_pkg::cfg_t     cfg,
  output pfl_pkg::result_t  result
);
  import pfl_pkg::*;

  phase_t              phase;
  phase_t              phase_next;
  logic [ENTRY_W-1:0]  entry;
  logic [ENTRY_W-1:0]  entry_next;
  logic [DCNT_W-1:0]   digit_count;
  logic [DCNT_W-1:0]   digit_count_next;
  logic [3:0]          try_count;
  logic [3:0]          try_count_next;
  logic [15:0]         elapsed;
  logic [15:0]         elapsed_next;

  logic                is_key;
  logic                is_fp;
  logic                is_tick;
  logic                is_digit;
  logic [DCNT_W-1:0]   cnt_inc;
  logic                pin_full;
  logic [ENTRY_W-1:0]  entry_shift;
  logic                pin_ok;
  logic [15:0]         el_inc;
  logic [3:0]          try_inc;
  logic                finger_hit;
  logic                lift_fail;
  logic [DCNT_W+2:0]   cnt_ext;
  event_t              ev;

  assign is_key      = (item.req_type == REQ_KEY);
  assign is_fp       = (item.req_type == REQ_FP);
  assign is_tick     = (item.req_type == REQ_TICK);
  assign is_digit    = (item.key_code <= KEY_LAST_DIGIT);
  assign cnt_inc     = digit_count + 1'b1;
  assign pin_full    = (cnt_inc == DCNT_W'(PIN_DIGITS));
  assign entry_shift = ENTRY_W'({entry, item.key_code});
  assign pin_ok      = (CMP_W'(entry_shift) == CMP_W'(cfg.pin_code));
  assign el_inc      = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 16'd1;
  assign try_inc     = (try_count == TRY_MAX) ? try_count : try_count + 4'd1;
  assign finger_hit  = (item.fp_status == FP_MATCH) && (item.fp_id == cfg.expected_finger);
  assign lift_fail   = (try_count >= cfg.max_tries) || (elapsed >= cfg.finger_timeout);

  // Next state of the controller and its counters.
  always_comb begin
    phase_next       = phase;
    entry_next       = entry;
    digit_count_next = digit_count;
    try_count_next   = try_count;
    elapsed_next     = elapsed;
    unique case (phase)
      PH_PIN: begin
        if (is_key && is_digit) begin
          if (pin_full) begin
            entry_next       = '0;
            digit_count_next = '0;
            elapsed_next     = '0;
            if (pin_ok) begin
              phase_next     = PH_FINGER;
              try_count_next = '0;
            end else begin
              phase_next = PH_LOCKOUT;
            end
          end else begin
            entry_next       = entry_shift;
            digit_count_next = cnt_inc;
          end
        end else if (is_key && item.key_code == KEY_STAR) begin
          entry_next       = '0;
          digit_count_next = '0;
        end
      end
      PH_FINGER: begin
        if (is_fp) begin
          if (finger_hit) begin
            phase_next   = PH_OPEN;
            elapsed_next = '0;
          end else if (item.fp_status != FP_NONE) begin
            try_count_next = try_inc;
            phase_next     = PH_REMOVE;
          end
        end else if (is_tick) begin
          elapsed_next = el_inc;
          if (el_inc >= cfg.finger_timeout) begin
            phase_next     = PH_PIN;
            try_count_next = '0;
          end
        end
      end
      PH_REMOVE: begin
        if (is_fp && item.fp_status == FP_NONE) begin
          if (lift_fail) begin
            phase_next     = PH_PIN;
            try_count_next = '0;
          end else begin
            phase_next = PH_FINGER;
          end
        end else if (is_tick) begin
          elapsed_next = el_inc;
        end
      end
      PH_OPEN: begin
        if (is_tick) begin
          elapsed_next = el_inc;
          if (el_inc >= cfg.unlock_ticks) begin
            phase_next     = PH_PIN;
            try_count_next = '0;
          end
        end
      end
      PH_LOCKOUT: begin
        if (is_tick) begin
          elapsed_next = el_inc;
          if (el_inc >= cfg.lockout_ticks) begin
            phase_next = PH_PIN;
          end
        end
      end
      default: begin
        phase_next = PH_PIN;
      end
    endcase
  end

  // Event code and result fields for the item being applied.
  always_comb begin
    ev = EV_NONE;
    unique case (phase)
      PH_PIN: begin
        if (is_key && is_digit && pin_full) begin
          ev = pin_ok ? EV_PIN_OK : EV_PIN_WRONG;
        end else if (is_key && item.key_code == KEY_STAR) begin
          ev = EV_CLEARED;
        end
      end
      PH_FINGER: begin
        if (is_fp) begin
          if (finger_hit) begin
            ev = EV_UNLOCKED;
          end else if (item.fp_status == FP_ERROR) begin
            ev = EV_FP_ERROR;
          end else if (item.fp_status != FP_NONE) begin
            ev = EV_FP_DENIED;
          end
        end else if (is_tick && el_inc >= cfg.finger_timeout) begin
          ev = EV_FP_FAIL;
        end
      end
      PH_REMOVE: begin
        if (is_fp && item.fp_status == FP_NONE && lift_fail) begin
          ev = EV_FP_FAIL;
        end
      end
      default: begin
        ev = EV_NONE;
      end
    endcase
    cnt_ext               = {3'b000, digit_count_next};
    result.phase          = phase_next;
    result.digits_entered = cnt_ext[2:0];
    result.event_code     = ev;
    result.tries_used     = try_count_next;
    result.unlock         = (phase_next == PH_OPEN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PIN;
      entry       <= '0;
      digit_count <= '0;
      try_count   <= '0;
      elapsed     <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      entry       <= entry_next;
      digit_count <= digit_count_next;
      try_count   <= try_count_next;
      elapsed     <= elapsed_next;
    end
  end

  a_digits_only_in_pin: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_PIN) |-> (digit_count == '0))
    else $error("digits held outside PIN entry");

  a_count_below_len: assert property (@(posedge clk) disable iff (rst)
    digit_count < DCNT_W'(PIN_DIGITS))
    else $error("stored digit count reached the PIN length");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(phase) && $stable(try_count) && $stable(elapsed)))
    else $error("state changed without an item");

  a_remove_tick_stays: assert property (@(posedge clk) disable iff (rst)
    (fire && phase == PH_REMOVE && is_tick) |=> (phase == PH_REMOVE))
    else $error("tick moved the controller out of await removal");

endmodule

FILE: hdl/pin_and_fingerprint_lock_fsm.sv
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     req_type key_code fp_status fp_id
// result    out        result_valid / result_stall phase digits_entered event_code
//                                                  tries_used unlock
// config    in         cfg_we                      cfg_index cfg_data
//
// One item is accepted per cycle while item_stall is low, and each item gives exactly one
// result, through the item register and then the result register.
// The rate is set by the phase, digit and timer registers, which are updated once per item.
// Reset (rst, synchronous, active high) returns the configuration to its defaults and
// the controller to PIN entry with all counters at zero.
// A stalled result holds in the result register while the next item waits in the item
// register; item_stall rises only when both registers are full.
module pin_and_fingerprint_lock_fsm (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  req_type,
  input  logic [3:0]  key_code,
  input  logic [1:0]  fp_status,
  input  logic [9:0]  fp_id,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  phase,
  output logic [2:0]  digits_entered,
  output logic [2:0]  event_code,
  output logic [3:0]  tries_used,
  output logic        unlock,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pfl_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_full;
  result_t res_comb;
  result_t res_q;
  logic    move;
  logic    accept;

  // The item in the item register is applied to the controller state in the same cycle
  // that its result enters the result register, so the next item always sees the state
  // that this one leaves behind.
  assign move       = item_full && (!result_valid || !result_stall);
  assign item_stall = item_full && !move;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (accept) begin
      item_full <= 1'b1;
    end else if (move) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q.req_type  <= req_type;
      item_q.key_code  <= key_code;
      item_q.fp_status <= fp_status;
      item_q.fp_id     <= fp_id;
    end
  end

  // The result register empties when its item is taken and no new one arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res_q <= res_comb;
    end
  end

  pfl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pfl_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (move),
    .item   (item_q),
    .cfg    (cfg),
    .result (res_comb)
  );

  assign phase          = res_q.phase;
  assign digits_entered = res_q.digits_entered;
  assign event_code     = res_q.event_code;
  assign tries_used     = res_q.tries_used;
  assign unlock         = res_q.unlock;

endmodule

FILE: sim/pin_and_fingerprint_lock_fsm_test.sv
`timescale 1ns / 1ps

module pin_and_fingerprint_lock_fsm_test;
  import pfl_pkg::*;

  // Codes the package does not name: the ignored hash key, the top key code,
  // the request type that the controller never acts on, and a register index
  // that maps to no register.
  localparam logic [3:0] KEY_HASH  = 4'd11;
  localparam logic [3:0] KEY_TOP   = 4'd15;
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [2:0] CFG_SPARE = 3'd7;

  // Run limit in clock cycles. Most of a correct run is spent in random stalls
  // and the long receiver hold-off.
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  logic [1:0]  req_type     = '0;
  logic [3:0]  key_code     = '0;
  logic [1:0]  fp_status    = '0;
  logic [9:0]  fp_id        = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  phase;
  logic [2:0]  digits_entered;
  logic [2:0]  event_code;
  logic [3:0]  tries_used;
  logic        unlock;
  logic        cfg_we       = 1'b0;
  logic [2:0]  cfg_index    = '0;
  logic [15:0] cfg_data     = '0;

  pin_and_fingerprint_lock_fsm u_top (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .req_type       (req_type),
    .key_code       (key_code),
    .fp_status      (fp_status),
    .fp_id          (fp_id),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .phase          (phase),
    .digits_entered (digits_entered),
    .event_code     (event_code),
    .tries_used     (tries_used),
    .unlock         (unlock),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Shadow copy of the lock controller. It is advanced once per accepted item,
  // in acceptance order, so its state always matches what the block has seen.
  cfg_t        lock_cfg = '{RST_PIN_CODE, RST_EXPECTED_FINGER, RST_MAX_TRIES,
                            RST_FINGER_TIMEOUT, RST_LOCKOUT_TICKS, RST_UNLOCK_TICKS};
  phase_t      lock_phase   = PH_PIN;
  logic [15:0] lock_entry   = '0;
  int          lock_count   = 0;
  logic [3:0]  lock_tries   = '0;
  logic [15:0] lock_elapsed = '0;

  // Status reports still owed by the block, oldest first.
  result_t status_due[$];

  bit idle_on  = 1'b1;
  int rx_hold  = 0;
  int errors   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int ev_seen[8];
  int cycle_count  = 0;

  // Apply one event to the shadow controller and return the status that the
  // block must report for it.
  function automatic result_t advance_lock(item_t it);
    event_t  ev;
    logic    pin_ok;
    result_t r;
    ev = EV_NONE;
    if (it.req_type == REQ_KEY && lock_phase == PH_PIN) begin
      if (it.key_code <= KEY_LAST_DIGIT) begin
        if (lock_count < PIN_DIGITS) begin
          lock_entry = (lock_entry << DIGIT_W) | ENTRY_W'(it.key_code);
          lock_count++;
        end
        // A full entry is always compared and then forgotten, right or wrong.
        if (lock_count >= PIN_DIGITS) begin
          pin_ok       = (CMP_W'(lock_entry) == CMP_W'(lock_cfg.pin_code));
          lock_entry   = '0;
          lock_count   = 0;
          lock_elapsed = '0;
          if (pin_ok) begin
            lock_phase = PH_FINGER;
            lock_tries = '0;
            ev         = EV_PIN_OK;
          end else begin
            lock_phase = PH_LOCKOUT;
            ev         = EV_PIN_WRONG;
          end
        end
      end else if (it.key_code == KEY_STAR) begin
        lock_entry = '0;
        lock_count = 0;
        ev         = EV_CLEARED;
      end
    end else if (it.req_type == REQ_FP && lock_phase == PH_FINGER) begin
      if (it.fp_status == FP_MATCH && it.fp_id == lock_cfg.expected_finger) begin
        lock_phase   = PH_OPEN;
        lock_elapsed = '0;
        ev           = EV_UNLOCKED;
      end else if (it.fp_status != FP_NONE) begin
        // A wrong ID, a no-match and a sensor error all count as a try.
        if (lock_tries < TRY_MAX) lock_tries++;
        ev         = (it.fp_status == FP_ERROR) ? EV_FP_ERROR : EV_FP_DENIED;
        lock_phase = PH_REMOVE;
      end
    end else if (it.req_type == REQ_FP && lock_phase == PH_REMOVE) begin
      // Only a lifted finger moves on; the try and time limits are judged here.
      if (it.fp_status == FP_NONE) begin
        if (lock_tries >= lock_cfg.max_tries || lock_elapsed >= lock_cfg.finger_timeout) begin
          lock_phase = PH_PIN;
          lock_tries = '0;
          ev         = EV_FP_FAIL;
        end else begin
          lock_phase = PH_FINGER;
        end
      end
    end else if (it.req_type == REQ_TICK && lock_phase != PH_PIN) begin
      if (lock_elapsed != ELAPSED_MAX) lock_elapsed++;
      case (lock_phase)
        PH_FINGER: begin
          if (lock_elapsed >= lock_cfg.finger_timeout) begin
            lock_phase = PH_PIN;
            lock_tries = '0;
            ev         = EV_FP_FAIL;
          end
        end
        PH_OPEN: begin
          if (lock_elapsed >= lock_cfg.unlock_ticks) begin
            lock_phase = PH_PIN;
            lock_tries = '0;
          end
        end
        PH_LOCKOUT: begin
          if (lock_elapsed >= lock_cfg.lockout_ticks) lock_phase = PH_PIN;
        end
        default: ;
      endcase
    end
    r.phase          = lock_phase;
    r.digits_entered = 3'(lock_count);
    r.event_code     = ev;
    r.tries_used     = lock_tries;
    r.unlock         = (lock_phase == PH_OPEN);
    return r;
  endfunction

  function automatic item_t key_item(logic [3:0] k);
    item_t it;
    it          = item_t'($urandom);
    it.req_type = REQ_KEY;
    it.key_code = k;
    return it;
  endfunction

  function automatic item_t fp_item(logic [1:0] st, logic [9:0] id);
    item_t it;
    it           = item_t'($urandom);
    it.req_type  = REQ_FP;
    it.fp_status = st;
    it.fp_id     = id;
    return it;
  endfunction

  function automatic item_t tick_item();
    item_t it;
    it          = item_t'($urandom);
    it.req_type = REQ_TICK;
    return it;
  endfunction

  // Choose the next event from the phase the controller is in, so that most
  // traffic walks the PIN, finger and hold path, with a share of noise left in.
  function automatic item_t pick_item();
    item_t it;
    int    roll;
    it   = item_t'($urandom);
    roll = $urandom_range(99);
    case (lock_phase)
      PH_PIN: begin
        if (roll < 70)
          it = key_item(lock_cfg.pin_code[DIGIT_W*(PIN_DIGITS-1-lock_count) +: DIGIT_W]);
        else if (roll < 80) it = key_item(4'($urandom_range(9)));
        else if (roll < 85) it = key_item(KEY_STAR);
        else if (roll < 89) it = key_item(4'($urandom_range(KEY_TOP, KEY_HASH)));
        else if (roll < 95) it = tick_item();
      end
      PH_FINGER: begin
        if (roll < 30) it = fp_item(FP_MATCH, lock_cfg.expected_finger);
        else if (roll < 60) it = fp_item(2'($urandom), 10'($urandom));
        else if (roll < 93) it = tick_item();
      end
      PH_REMOVE: begin
        if (roll < 50) it = fp_item(FP_NONE, 10'($urandom));
        else if (roll < 60) it = fp_item(2'($urandom_range(3, 1)), 10'($urandom));
        else if (roll < 93) it = tick_item();
      end
      default: begin
        if (roll < 85) it = tick_item();
      end
    endcase
    return it;
  endfunction

  // Offer one item and hold it until the block takes it. Valid is left high on
  // return so that back-to-back items keep it asserted without a gap.
  task automatic offer_item(input item_t it);
    if (idle_on) begin
      while ($urandom_range(99) < 15) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    req_type   <= it.req_type;
    key_code   <= it.key_code;
    fp_status  <= it.fp_status;
    fp_id      <= it.fp_id;
    do @(posedge clk); while (item_stall);
    status_due.push_back(advance_lock(it));
    items_sent++;
  endtask

  // Stop offering and wait until every owed status has come back.
  task automatic wait_quiet();
    item_valid <= 1'b0;
    do @(posedge clk); while (status_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write of a group.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_PIN_CODE:        lock_cfg.pin_code        = data;
      CFG_EXPECTED_FINGER: lock_cfg.expected_finger = data[9:0];
      CFG_MAX_TRIES:       lock_cfg.max_tries       = data[3:0];
      CFG_FINGER_TIMEOUT:  lock_cfg.finger_timeout  = data;
      CFG_LOCKOUT_TICKS:   lock_cfg.lockout_ticks   = data;
      CFG_UNLOCK_TICKS:    lock_cfg.unlock_ticks    = data;
      default: ;
    endcase
  endtask

  // Write every register, plus one write to an unmapped index that must be
  // ignored. Only called with nothing outstanding.
  task automatic load_settings(input cfg_t c);
    write_reg(CFG_PIN_CODE, c.pin_code);
    write_reg(CFG_EXPECTED_FINGER, 16'(c.expected_finger));
    write_reg(CFG_MAX_TRIES, 16'(c.max_tries));
    write_reg(CFG_FINGER_TIMEOUT, c.finger_timeout);
    write_reg(CFG_LOCKOUT_TICKS, c.lockout_ticks);
    write_reg(CFG_UNLOCK_TICKS, c.unlock_ticks);
    write_reg(CFG_SPARE, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic enter_pin(input logic [15:0] pin);
    for (int d = PIN_DIGITS - 1; d >= 0; d--) offer_item(key_item(pin[DIGIT_W*d +: DIGIT_W]));
  endtask

  // Reset settings: ignored events of every kind, the star clear, a correct
  // PIN and a finger stage that runs out of tries through each failure type.
  task automatic test_directed_defaults();
    item_t junk;
    junk = '{REQ_SPARE, KEY_TOP, FP_ERROR, 10'h3FF};
    offer_item(tick_item());
    offer_item(key_item(KEY_HASH));
    offer_item(key_item(KEY_TOP));
    offer_item(junk);
    offer_item(fp_item(FP_MATCH, RST_EXPECTED_FINGER));
    offer_item(key_item(4'd9));
    offer_item(key_item(4'd0));
    offer_item(key_item(KEY_STAR));
    enter_pin(RST_PIN_CODE);
    offer_item(fp_item(FP_NONE, 10'd0));
    offer_item(fp_item(FP_MATCH, 10'h3FF));
    offer_item(fp_item(FP_ERROR, 10'd0));
    offer_item(tick_item());
    offer_item(fp_item(FP_NONE, 10'h3FF));
    offer_item(key_item(4'd1));
    offer_item(fp_item(FP_ERROR, 10'h2AA));
    offer_item(fp_item(FP_NONE, 10'd0));
    offer_item(fp_item(FP_NOMATCH, 10'h155));
    offer_item(fp_item(FP_NONE, 10'd0));
    offer_item(tick_item());
  endtask

  // All limits at zero: the stage fails on its first tick and at its first
  // lift, and the unlock hold and the lockout end on the next tick.
  task automatic test_zero_limits();
    wait_quiet();
    load_settings('{16'h9999, 10'h3FF, 4'd0, 16'd0, 16'd0, 16'd0});
    enter_pin(16'h9999);
    offer_item(tick_item());
    enter_pin(16'h9999);
    offer_item(fp_item(FP_NOMATCH, 10'h3FF));
    offer_item(fp_item(FP_NONE, 10'd0));
    enter_pin(16'h9999);
    offer_item(fp_item(FP_MATCH, 10'h3FF));
    offer_item(tick_item());
    enter_pin(16'h1234);
    offer_item(key_item(4'd9));
    offer_item(tick_item());
  endtask

  // The receiver holds off for a long stretch while items keep coming, so both
  // internal registers fill and the block has to stall its input.
  task automatic test_backpressure();
    wait_quiet();
    load_settings('{16'h4682, 10'd7, 4'd2, 16'd20, 16'd6, 16'd6});
    idle_on = 1'b0;
    rx_hold = 300;
    repeat (60) offer_item(pick_item());
    idle_on = 1'b1;
  endtask

  // A series of random settings, extremes among them, each followed by a
  // stretch of phase-aware random traffic. One stretch runs with no idling.
  task automatic test_random_settings();
    cfg_t c;
    for (int k = 0; k < 8; k++) begin
      c.pin_code        = {4'($urandom_range(9)), 4'($urandom_range(9)),
                           4'($urandom_range(9)), 4'($urandom_range(9))};
      c.expected_finger = 10'($urandom);
      c.max_tries       = 4'($urandom_range(5, 1));
      c.finger_timeout  = 16'($urandom_range(60, 5));
      c.lockout_ticks   = 16'($urandom_range(30));
      c.unlock_ticks    = 16'($urandom_range(30));
      case (k)
        1: c.max_tries = 4'd1;
        2: c.pin_code = 16'h9999;
        3: begin
          c.pin_code        = 16'h0000;
          c.expected_finger = 10'd0;
        end
        4: begin
          c.max_tries       = 4'd15;
          c.finger_timeout  = 16'hFFFF;
          c.expected_finger = 10'h3FF;
        end
        // No digit can match a nibble above nine, so every full entry is wrong.
        5: c.pin_code = 16'hFFFF;
        6: begin
          c.max_tries      = 4'd0;
          c.finger_timeout = 16'd1;
        end
        7: begin
          c.lockout_ticks = 16'hFFFF;
          c.unlock_ticks  = 16'hFFFF;
        end
        default: ;
      endcase
      wait_quiet();
      load_settings(c);
      idle_on = (k != 3);
      repeat (120) offer_item(pick_item());
    end
    idle_on = 1'b1;
  endtask

  // The widest finger timeout with the full try budget: a run of ticks in
  // await removal only counts, the lift returns to await finger, and the
  // matching finger then opens the lock until the hold runs out.
  task automatic test_long_timeout();
    wait_quiet();
    load_settings('{16'h1357, 10'h155, 4'd15, 16'hFFFF, 16'd5, 16'd5});
    idle_on = 1'b0;
    enter_pin(16'h1357);
    offer_item(fp_item(FP_NOMATCH, 10'h2AA));
    repeat (40) offer_item(tick_item());
    offer_item(fp_item(FP_NONE, 10'd0));
    offer_item(fp_item(FP_MATCH, 10'h155));
    repeat (6) offer_item(tick_item());
    idle_on = 1'b1;
  endtask

  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        result_stall <= 1'b1;
        rx_hold--;
      end else begin
        result_stall <= idle_on && ($urandom_range(99) < 15);
      end
    end
  end

  // Every accepted status is compared, field by field, with the oldest one owed.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      got.phase          = phase_t'(phase);
      got.digits_entered = digits_entered;
      got.event_code     = event_t'(event_code);
      got.tries_used     = tries_used;
      got.unlock         = unlock;
      if (status_due.size() == 0) begin
        $error("status reported with no item outstanding");
        errors++;
      end else begin
        want = status_due.pop_front();
        results_seen++;
        ev_seen[int'(got.event_code)]++;
        if (got.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, got.phase);
          errors++;
        end
        if (got.digits_entered !== want.digits_entered) begin
          $error("digits_entered: expected %0d, got %0d",
                 want.digits_entered, got.digits_entered);
          errors++;
        end
        if (got.event_code !== want.event_code) begin
          $error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
          errors++;
        end
        if (got.tries_used !== want.tries_used) begin
          $error("tries_used: expected %0d, got %0d", want.tries_used, got.tries_used);
          errors++;
        end
        if (got.unlock !== want.unlock) begin
          $error("unlock: expected %0d, got %0d", want.unlock, got.unlock);
          errors++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_zero_limits();
    test_backpressure();
    test_random_settings();
    test_long_timeout();
    wait_quiet();
    repeat (8) @(posedge clk);
    $display("Sent %0d events and checked %0d status reports across 12 register settings.",
             items_sent, results_seen);
    $display("Seen: %0d PIN ok, %0d PIN wrong, %0d unlocks, %0d finger stage failures.",
             ev_seen[EV_PIN_OK], ev_seen[EV_PIN_WRONG], ev_seen[EV_UNLOCKED],
             ev_seen[EV_FP_FAIL]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
